### sv/tsm_pkg.sv
// Shared types and codes for the two-way sorted merge block.
`default_nettype none
package tsm_pkg;

  localparam logic [1:0] ACT_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] ACT_APPEND_SECOND = 2'd1;
  localparam logic [1:0] ACT_MERGE         = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] merged_value;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_APPEND_FIRST,
    OP_APPEND_SECOND,
    OP_MERGE
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic signed [31:0] value;
  } op_t;

endpackage
`default_nettype wire

### sv/two_way_sorted_merge.sv
// Top level: two-way sorted merge. An append is queued on acceptance and written to its list
// when the sequencer pops it. A merge runs through the queue, the S_PREP and S_MERGE states
// and the result register, then yields one result per cycle; an empty merge gives no result.
// Appends and merges queue two deep ahead of the sequencer; busy rises when the queue fills.
// Results cannot be stalled. Synchronous active-low reset empties the queue and both lists.
`default_nettype none
module two_way_sorted_merge #(
  parameter int LIST_CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tsm_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output tsm_pkg::out_item_t out_item
);
  import tsm_pkg::*;

  logic q_valid;
  logic q_pop;
  op_t  q_op;

  tsm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop)
  );

  tsm_back #(.LIST_CAPACITY(LIST_CAPACITY)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last_of_run |=> !out_strobe)
    else $error("result after end of merge run");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last_of_run |=> out_strobe)
    else $error("gap inside merge run");

  a_full_queue: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> q_valid)
    else $error("busy with empty queue");

endmodule
`default_nettype wire

### sv/tsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### sv/tsm_front.sv
// Front end: accepts items, drops unused actions, queues operations for the back end.
`default_nettype none
module tsm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  tsm_pkg::in_item_t in_item,
  output logic             busy,
  output logic             q_valid,
  output tsm_pkg::op_t     q_op,
  input  logic             q_pop
);
  import tsm_pkg::*;

  op_t        q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       known;
  logic       push;
  logic       pop;
  op_t        op_new;

  always_comb begin
    known       = 1'b1;
    op_new.kind = OP_MERGE;
    op_new.value = in_item.value;
    case (in_item.action)
      ACT_APPEND_FIRST:  op_new.kind = OP_APPEND_FIRST;
      ACT_APPEND_SECOND: op_new.kind = OP_APPEND_SECOND;
      ACT_MERGE:         op_new.kind = OP_MERGE;
      default:           known = 1'b0;
    endcase
  end

  assign busy    = (fill_r == 2'd2);
  assign q_valid = (fill_r != 2'd0);
  assign q_op    = q_mem_r[rd_ptr_r];
  assign push    = start && !busy && known;
  assign pop     = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + 2'd1;
      2'b01:   fill_nxt = fill_r - 2'd1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= op_new;
    end
  end

endmodule
`default_nettype wire

### sv/tsm_back.sv
// Back end: list stores, counts and the merge sequencer with registered result.
`default_nettype none
module tsm_back #(
  parameter int LIST_CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tsm_pkg::op_t       q_op,
  output logic               q_pop,
  output logic               out_strobe,
  output tsm_pkg::out_item_t out_item
);
  import tsm_pkg::*;

  localparam int CW = $clog2(LIST_CAPACITY + 1);
  localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam logic [CW-1:0] CAP = CW'(LIST_CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_MERGE
  } state_t;

  state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic [CW-1:0] ia_inc, ib_inc;
  logic      out_strobe_r, out_strobe_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic        we_a, we_b;
  logic [31:0] head_a, head_b;
  logic        a_ok, b_ok, take_a, last;

  tsm_ram #(.WIDTH(32), .DEPTH(LIST_CAPACITY)) u_ram_a (
    .clk     (clk),
    .wr_en   (we_a),
    .wr_addr (cnt_a_r[AW-1:0]),
    .wr_data (q_op.value),
    .rd_addr (ia_nxt[AW-1:0]),
    .rd_data (head_a)
  );

  tsm_ram #(.WIDTH(32), .DEPTH(LIST_CAPACITY)) u_ram_b (
    .clk     (clk),
    .wr_en   (we_b),
    .wr_addr (cnt_b_r[AW-1:0]),
    .wr_data (q_op.value),
    .rd_addr (ib_nxt[AW-1:0]),
    .rd_data (head_b)
  );

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign we_a  = q_pop && (q_op.kind == OP_APPEND_FIRST) && (cnt_a_r < CAP);
  assign we_b  = q_pop && (q_op.kind == OP_APPEND_SECOND) && (cnt_b_r < CAP);

  // ties go to the second list
  assign a_ok   = (ia_r < cnt_a_r);
  assign b_ok   = (ib_r < cnt_b_r);
  assign take_a = a_ok && (!b_ok || ($signed(head_a) < $signed(head_b)));
  assign ia_inc = ia_r + {{(CW-1){1'b0}}, take_a};
  assign ib_inc = ib_r + {{(CW-1){1'b0}}, !take_a};
  assign last   = (ia_inc == cnt_a_r) && (ib_inc == cnt_b_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    case (state_r)
      S_IDLE: begin
        if (we_a) begin
          cnt_a_nxt = cnt_a_r + {{(CW-1){1'b0}}, 1'b1};
        end
        if (we_b) begin
          cnt_b_nxt = cnt_b_r + {{(CW-1){1'b0}}, 1'b1};
        end
        if (q_pop && (q_op.kind == OP_MERGE) &&
            ((cnt_a_r != '0) || (cnt_b_r != '0))) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        out_strobe_nxt            = 1'b1;
        out_item_nxt.merged_value = take_a ? head_a : head_b;
        out_item_nxt.last_of_run  = last;
        if (last) begin
          state_nxt = S_IDLE;
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
          ia_nxt    = '0;
          ib_nxt    = '0;
        end else begin
          ia_nxt = ia_inc;
          ib_nxt = ib_inc;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      ia_r         <= '0;
      ib_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      ia_r         <= ia_nxt;
      ib_r         <= ib_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_item_r   <= out_item_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
`default_nettype wire

### dv/two_way_sorted_merge_checker.sv
`timescale 1ns / 100ps
// Checker for the two-way sorted merge: mirrors both lists, orders each merge, compares results.
module two_way_sorted_merge_checker #(
  parameter int LIST_CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  tsm_pkg::in_item_t  in_item,
  input  logic               out_strobe,
  input  tsm_pkg::out_item_t out_item,
  output int                 mismatches,
  output int                 outstanding
);
  import tsm_pkg::*;

  logic signed [31:0] first_list[$];
  logic signed [31:0] second_list[$];
  out_item_t          merged_backlog[$];
  int                 fault_total = 0;

  task automatic flag_fault(string msg);
    if (fault_total < 10) $display("%s", msg);
    fault_total++;
  endtask

  // Smaller head first; on a tie the second list's head goes out.
  task automatic merge_lists();
    int        ia;
    int        ib;
    int        total;
    out_item_t r;
    ia    = 0;
    ib    = 0;
    total = first_list.size() + second_list.size();
    for (int n = 0; n < total; n++) begin
      if (ia < first_list.size() &&
          (ib >= second_list.size() || first_list[ia] < second_list[ib])) begin
        r.merged_value = first_list[ia];
        ia++;
      end else begin
        r.merged_value = second_list[ib];
        ib++;
      end
      r.last_of_run = (n == total - 1);
      merged_backlog.push_back(r);
    end
    first_list.delete();
    second_list.delete();
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      first_list.delete();
      second_list.delete();
      merged_backlog.delete();
    end else begin
      if (out_strobe) begin
        if (merged_backlog.size() == 0) begin
          flag_fault($sformatf("unexpected item: merged_value %0d last_of_run %0b",
                               out_item.merged_value, out_item.last_of_run));
        end else begin
          want = merged_backlog.pop_front();
          if (out_item.merged_value !== want.merged_value)
            flag_fault($sformatf("merged_value mismatch: expected %0d got %0d",
                                 want.merged_value, out_item.merged_value));
          if (out_item.last_of_run !== want.last_of_run)
            flag_fault($sformatf("last_of_run mismatch: expected %0b got %0b (value %0d)",
                                 want.last_of_run, out_item.last_of_run,
                                 want.merged_value));
        end
      end
      if (start && !busy) begin
        case (in_item.action)
          ACT_APPEND_FIRST: begin
            if (first_list.size() < LIST_CAPACITY) first_list.push_back(in_item.value);
          end
          ACT_APPEND_SECOND: begin
            if (second_list.size() < LIST_CAPACITY) second_list.push_back(in_item.value);
          end
          ACT_MERGE: begin
            merge_lists();
          end
          default: begin
          end
        endcase
      end
    end
    mismatches  <= fault_total;
    outstanding <= merged_backlog.size();
  end

endmodule

### dv/two_way_sorted_merge_tb.sv
`timescale 1ns / 100ps
// Testbench top for the two-way sorted merge: clock, reset, item stimulus and verdict.
module two_way_sorted_merge_tb;
  import tsm_pkg::*;

  localparam logic [1:0]         ACT_UNUSED    = 2'd3;
  localparam int                 LIST_CAPACITY = 32;
  localparam int                 ITEM_TARGET   = 450;
  localparam int                 CALM_FROM     = 380;
  localparam int                 TAIL_CYCLES   = 100;
  localparam int                 CYCLE_LIMIT   = 400000;
  localparam logic signed [31:0] VAL_MIN       = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX       = 32'sh7fff_ffff;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  cmd_item;
  logic      out_strobe;
  out_item_t merge_out;
  int        mismatches;
  int        outstanding;
  int        cycles = 0;
  int        sent = 0;
  bit        idle_on = 1'b0;

  always #4 clk = ~clk;

  two_way_sorted_merge #(
    .LIST_CAPACITY(LIST_CAPACITY)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (cmd_item),
    .out_strobe(out_strobe),
    .out_item  (merge_out)
  );

  two_way_sorted_merge_checker #(
    .LIST_CAPACITY(LIST_CAPACITY)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (cmd_item),
    .out_strobe (out_strobe),
    .out_item   (merge_out),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_elem();
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3, 4: return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 0;
    if (r < 4) return $urandom_range(30, 36);
    return $urandom_range(1, 8);
  endfunction

  task automatic pause_sender(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every merged item has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send(logic [1:0] act, logic signed [31:0] val);
    cmd_item <= '{action: act, value: val};
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    if (act != ACT_UNUSED) sent++;
    if (idle_on && sent < CALM_FROM && $urandom_range(0, 4) == 0)
      pause_sender($urandom_range(1, 11));
  endtask

  task automatic run_sequence(int n1, int n2, bit sorted, bit do_merge);
    int q1[$];
    int q2[$];
    repeat (n1) q1.push_back(rand_elem());
    repeat (n2) q2.push_back(rand_elem());
    if (sorted) begin
      q1.sort();
      q2.sort();
    end
    while (q1.size() + q2.size() > 0) begin
      if ($urandom_range(0, 14) == 0) send(ACT_UNUSED, rand_elem());
      if (q2.size() == 0 || (q1.size() > 0 && $urandom_range(0, 1) == 0))
        send(ACT_APPEND_FIRST, q1.pop_front());
      else
        send(ACT_APPEND_SECOND, q2.pop_front());
    end
    if (do_merge) send(ACT_MERGE, rand_elem());
  endtask

  initial begin
    int n1;
    int n2;
    int seq;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    cmd_item <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty merge, unused action
    send(ACT_MERGE, VAL_MAX);
    send(ACT_UNUSED, 32'shffff_ffff);
    // extremes and ties at min, zero and max
    send(ACT_APPEND_FIRST, VAL_MIN);
    send(ACT_APPEND_SECOND, VAL_MIN);
    send(ACT_APPEND_FIRST, -1);
    send(ACT_APPEND_SECOND, 0);
    send(ACT_APPEND_FIRST, 0);
    send(ACT_APPEND_SECOND, VAL_MAX);
    send(ACT_APPEND_FIRST, VAL_MAX);
    send(ACT_MERGE, 0);
    // one list only
    send(ACT_APPEND_FIRST, 7);
    send(ACT_MERGE, 0);
    send(ACT_APPEND_SECOND, -3);
    send(ACT_APPEND_SECOND, 9);
    send(ACT_MERGE, 0);
    // unsorted lists
    send(ACT_APPEND_FIRST, 10);
    send(ACT_APPEND_FIRST, 2);
    send(ACT_APPEND_SECOND, 5);
    send(ACT_APPEND_SECOND, 1);
    send(ACT_MERGE, 0);
    // counts cleared by the merge
    send(ACT_MERGE, 0);
    drain();

    seq = 0;
    while (sent < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case (seq)
        0: begin
          n1 = LIST_CAPACITY + 2;
          n2 = 3;
        end
        1: begin
          n1 = 2;
          n2 = LIST_CAPACITY + 3;
        end
        default: begin
          n1 = pick_len();
          n2 = pick_len();
        end
      endcase
      run_sequence(n1, n2, $urandom_range(0, 4) != 0, $urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) == 0) send(ACT_MERGE, rand_elem());
      if (sent < CALM_FROM && $urandom_range(0, 4) == 0) drain();
      seq++;
    end
    send(ACT_MERGE, rand_elem());
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
